// ----- rtl/core/dssd_pkg.sv -----
// Shared types and constants for the decimal seven-segment serial driver.
// Holds the queue entry type and the digit-to-segment table.
// No dependencies.
`default_nettype none
package dssd_pkg;

   localparam int unsigned BitsPerDigit = 16;
   localparam int unsigned QueueDepth   = 4;
   localparam logic [7:0]  EnableBase   = 8'h10;
   // Reciprocal of ten scaled by 2^19, exact for every 16-bit dividend.
   localparam logic [15:0] RecipTen     = 16'd52429;

   // One decoded digit, handed from the front end to the serializer.
   typedef struct packed {
      logic [7:0] seg;
      logic [1:0] idx;
      logic       last;
   } digit_entry_type;

   // Active-low segment pattern of a decimal digit.
   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'd0:    pat = 8'h03;
         4'd1:    pat = 8'h9F;
         4'd2:    pat = 8'h25;
         4'd3:    pat = 8'h0D;
         4'd4:    pat = 8'h99;
         4'd5:    pat = 8'h49;
         4'd6:    pat = 8'h41;
         4'd7:    pat = 8'h1F;
         4'd8:    pat = 8'h01;
         4'd9:    pat = 8'h09;
         default: pat = 8'hFF;
      endcase
      return pat;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dssd_front.sv -----
// Front end: accepts a value and splits it into decimal digits, one per cycle while the queue accepts them.
// Depends on dssd_pkg.
`default_nettype none
module dssd_front #(
   parameter int unsigned DIGIT_COUNT = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [15:0]               req_shown_value,
   output logic                           push_valid,
   input  wire logic                      push_ready,
   output dssd_pkg::digit_entry_type      push_data
);
   import dssd_pkg::*;

   // A digit count outside one to four is pulled back into that range.
   localparam int unsigned DigitsUsed = (DIGIT_COUNT < 1) ? 1 :
                                        (DIGIT_COUNT > 4) ? 4 : DIGIT_COUNT;
   localparam logic [1:0] LastIdx = 2'(DigitsUsed - 1);

   logic        busy_ff, busy_in;
   logic [15:0] val_ff, val_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] prod;
   logic [12:0] quot;
   logic [15:0] quot_x10;
   logic [3:0]  rem;
   logic        is_last;
   logic        push;

   // Divide by ten through the reciprocal; the remainder is the digit.
   always_comb begin
      prod     = 32'(val_ff) * 32'(RecipTen);
      quot     = prod[31:19];
      quot_x10 = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
      rem      = 4'(val_ff - quot_x10);
   end

   assign is_last    = (idx_ff == LastIdx);
   assign req_ready  = !busy_ff;
   assign push_valid = busy_ff;
   assign push       = busy_ff && push_ready;
   assign push_data  = '{seg: seg_of(rem), idx: idx_ff, last: is_last};

   // Next state of the digit walk.
   always_comb begin
      busy_in = busy_ff;
      val_in  = val_ff;
      idx_in  = idx_ff;
      if (req_valid && req_ready) begin
         busy_in = 1'b1;
         val_in  = req_shown_value;
         idx_in  = '0;
      end else if (push) begin
         val_in  = 16'(quot);
         idx_in  = idx_ff + 2'd1;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      val_ff <= val_in;
      idx_ff <= idx_in;
   end

endmodule
`default_nettype wire

// ----- rtl/core/dssd_queue.sv -----
// Short FIFO of decoded digits between the front end and the serializer.
// Depends on dssd_pkg.
`default_nettype none
module dssd_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_valid,
   output logic                           push_ready,
   input  dssd_pkg::digit_entry_type      push_data,
   output logic                           pop_valid,
   input  wire logic                      pop_ready,
   output dssd_pkg::digit_entry_type      pop_data
);
   import dssd_pkg::*;

   localparam int unsigned PtrW = $clog2(QueueDepth);

   digit_entry_type       mem_ff [QueueDepth];
   logic [PtrW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]         count_ff;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != (PtrW + 1)'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/dssd_back.sv -----
// Serializer: shifts each digit's segment and enable bytes out LSB first.
// Depends on dssd_pkg.
`default_nettype none
module dssd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      pop_valid,
   output logic                           pop_ready,
   input  dssd_pkg::digit_entry_type      pop_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_serial_bit,
   output logic                           rsp_latch_pulse,
   output logic [1:0]                     rsp_digit_index,
   output logic                           rsp_last_of_run
);
   import dssd_pkg::*;

   localparam int unsigned CntW = $clog2(BitsPerDigit);

   logic                have_ff;
   logic [BitsPerDigit-1:0] word_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [1:0]          idx_ff;
   logic                last_ff;
   logic                out_valid_ff;
   logic                out_bit_ff, out_latch_ff, out_last_ff;
   logic [1:0]          out_idx_ff;
   logic                adv, end_digit;

   assign end_digit = (cnt_ff == CntW'(BitsPerDigit - 1));
   assign adv       = have_ff && (!out_valid_ff || rsp_ready);
   assign pop_ready = !have_ff || (adv && end_digit);

   // Shift register holding the current digit's sixteen bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (pop_valid && pop_ready) begin
         have_ff <= 1'b1;
      end else if (adv && end_digit) begin
         have_ff <= 1'b0;
      end
      if (pop_valid && pop_ready) begin
         word_ff <= {8'(EnableBase << pop_data.idx), pop_data.seg};
         cnt_ff  <= '0;
         idx_ff  <= pop_data.idx;
         last_ff <= pop_data.last;
      end else if (adv) begin
         word_ff <= word_ff >> 1;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   // Output register; a bit waits here while the next one is prepared.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (adv) begin
         out_bit_ff   <= word_ff[0];
         out_latch_ff <= end_digit;
         out_idx_ff   <= idx_ff;
         out_last_ff  <= last_ff && end_digit;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_serial_bit  = out_bit_ff;
   assign rsp_latch_pulse = out_latch_ff;
   assign rsp_digit_index = out_idx_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule
`default_nettype wire

// ----- rtl/core/decimal_seven_segment_serial_driver.sv -----
// Top level of the decimal seven-segment serial driver.
// Depends on dssd_pkg, dssd_front, dssd_queue and dssd_back.
//
// Each accepted value yields 16 * DIGIT_COUNT serial-bit transactions, with
// DIGIT_COUNT held to one to four (64 at four digits): per digit, least
// significant first, the active-low segment byte and then the digit-enable
// byte, both LSB first, with latch_pulse set on the sixteenth bit and
// last_of_run on the final bit of the value. The serializer emits one bit
// per cycle while rsp_ready is held; the front end divides by ten once per
// digit and runs ahead through a four-entry digit queue, so the next value
// is accepted while earlier bits are still being shifted out.
`default_nettype none
module decimal_seven_segment_serial_driver #(
   parameter int unsigned DIGIT_COUNT = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_shown_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_serial_bit,
   output logic             rsp_latch_pulse,
   output logic [1:0]       rsp_digit_index,
   output logic             rsp_last_of_run
);
   import dssd_pkg::*;

   digit_entry_type push_data, pop_data;
   logic            push_valid, push_ready, pop_valid, pop_ready;

   dssd_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_shown_value (req_shown_value),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   dssd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   dssd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_pulse (rsp_latch_pulse),
      .rsp_digit_index (rsp_digit_index),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
`default_nettype wire

// ----- rtl/core/dssd_checker.sv -----
// Port-level checks for the decimal seven-segment serial driver.
// Bound to decimal_seven_segment_serial_driver; no other dependencies.
`default_nettype none
module dssd_checker #(
   parameter int unsigned DIGIT_COUNT = 4
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_serial_bit,
   input wire logic        rsp_latch_pulse,
   input wire logic [1:0]  rsp_digit_index,
   input wire logic        rsp_last_of_run
);

   // The digit count is pulled back into one to four, as in the design.
   localparam int unsigned DigitsUsed = (DIGIT_COUNT < 1) ? 1 :
                                        (DIGIT_COUNT > 4) ? 4 : DIGIT_COUNT;
   localparam logic [1:0]  TopIdx     = 2'(DigitsUsed - 1);

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_serial_bit)
         && $stable(rsp_latch_pulse) && $stable(rsp_digit_index)
         && $stable(rsp_last_of_run))
      else $error("result payload changed while stalled");

   // The final bit of a value always closes a digit, and that digit is the top one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |->
         rsp_latch_pulse && rsp_digit_index == TopIdx)
      else $error("last bit not on the latch of the top digit");

   // Within a digit the index does not change between bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_latch_pulse |=>
         !rsp_valid || rsp_digit_index == $past(rsp_digit_index))
      else $error("digit index changed inside a digit");

   // The digit index never exceeds the configured digit count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_index <= TopIdx)
      else $error("digit index out of range");

endmodule

bind decimal_seven_segment_serial_driver
   dssd_checker #(.DIGIT_COUNT(DIGIT_COUNT)) u_dssd_checker (
      .clock           (clock),
      .reset           (reset),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_latch_pulse (rsp_latch_pulse),
      .rsp_digit_index (rsp_digit_index),
      .rsp_last_of_run (rsp_last_of_run)
   );
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for decimal_seven_segment_serial_driver.
// Drives shown values, predicts the serial bit stream of each value and
// checks every bit transaction in order. Depends on dssd_pkg and the RTL.
`default_nettype none
module tb_top;
   import dssd_pkg::*;

   localparam int unsigned DIGIT_COUNT  = 4;
   localparam int unsigned DigitsShown  = (DIGIT_COUNT < 1) ? 1 :
                                          (DIGIT_COUNT > 4) ? 4 : DIGIT_COUNT;
   localparam int unsigned IdleLimit    = 2000;
   localparam int unsigned DrainCycles  = 40;
   localparam int unsigned MaxReported  = 30;
   localparam int unsigned RandomValues = 150;

   // Active-low segment codes, indexed by decimal digit.
   localparam logic [7:0] SegCode [10] = '{
      8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09
   };

   // One expected serial bit transaction.
   typedef struct packed {
      logic       serial_bit;
      logic       latch_pulse;
      logic [1:0] digit_index;
      logic       last_of_run;
   } serial_bit_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_shown_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_serial_bit;
   logic        rsp_latch_pulse;
   logic [1:0]  rsp_digit_index;
   logic        rsp_last_of_run;

   serial_bit_type pending_bits[$];
   int unsigned    error_count = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    burst_left  = 0;
   bit             sender_gaps = 1'b1;

   decimal_seven_segment_serial_driver #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_shown_value(req_shown_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_serial_bit (rsp_serial_bit),
      .rsp_latch_pulse(rsp_latch_pulse),
      .rsp_digit_index(rsp_digit_index),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Prints one mismatch line and counts it; the print is capped to keep logs short.
   task automatic report_mismatch(input string what);
      if (error_count < MaxReported) begin
         $display("ERROR @%0t: %s", $realtime, what);
      end
      error_count++;
   endtask

   // Appends the serial bits that one shown value produces: per digit, the
   // segment byte and then the enable byte, both LSB first.
   function automatic void queue_value_bits(input logic [15:0] value);
      int unsigned    rest;
      int unsigned    total;
      int unsigned    k;
      logic [15:0]    word;
      logic [7:0]     enable;
      serial_bit_type one;
      rest  = 32'(value);
      total = DigitsShown * BitsPerDigit;
      k     = 0;
      for (int unsigned d = 0; d < DigitsShown; d++) begin
         enable = EnableBase << d;
         word   = {enable, SegCode[rest % 10]};
         rest   = rest / 10;
         for (int unsigned b = 0; b < BitsPerDigit; b++) begin
            one.serial_bit  = word[b];
            one.latch_pulse = (b == BitsPerDigit - 1);
            one.digit_index = d[1:0];
            one.last_of_run = (k == total - 1);
            pending_bits.push_back(one);
            k++;
         end
      end
   endfunction

   // Predicts on each accepted value and checks each accepted bit transaction.
   always @(posedge clock) begin
      serial_bit_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            queue_value_bits(req_shown_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_bits.size() == 0) begin
               report_mismatch("bit transaction with nothing pending");
            end else begin
               want = pending_bits.pop_front();
               if (rsp_serial_bit !== want.serial_bit)
                  report_mismatch($sformatf("serial_bit %b, want %b",
                                            rsp_serial_bit, want.serial_bit));
               if (rsp_latch_pulse !== want.latch_pulse)
                  report_mismatch($sformatf("latch_pulse %b, want %b",
                                            rsp_latch_pulse, want.latch_pulse));
               if (rsp_digit_index !== want.digit_index)
                  report_mismatch($sformatf("digit_index %0d, want %0d",
                                            rsp_digit_index, want.digit_index));
               if (rsp_last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, want %b",
                                            rsp_last_of_run, want.last_of_run));
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IdleLimit) begin
            $display("FAIL decimal_seven_segment_serial_driver");
            $finish;
         end
      end
   end

   // Receiver stalls follow their own schedule of modes: always ready,
   // periodic stalls, random stalls and solid stall runs.
   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned period;
      rsp_ready = 1'b0;
      forever begin
         mode   = $urandom_range(0, 3);
         span   = $urandom_range(20, 200);
         period = $urandom_range(2, 5);
         for (int unsigned c = 0; c < span; c++) begin
            @(negedge clock);
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= (c % period) != 0;
               end
               2: begin
                  rsp_ready <= ($urandom_range(0, 9) >= 4);
               end
               default: begin
                  rsp_ready <= ((c / 16) % 2) == 1;
               end
            endcase
         end
      end
   end

   // Presents one value and holds it until the transaction is accepted, then
   // inserts a random gap at the end of each burst.
   task automatic send_value(input logic [15:0] value);
      int unsigned gap;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_shown_value <= value;
      do begin
         @(posedge clock);
      end while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = sender_gaps ? $urandom_range(0, 70) : 0;
         if ($urandom_range(0, 9) < 3) begin
            gap = 0;
         end
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end
      end
   endtask

   // Field extremes and digit carries, including values above 9999.
   task automatic test_extremes();
      logic [15:0] values [8] = '{16'd0, 16'd9, 16'd10, 16'd999, 16'd9999,
                                  16'd10000, 16'd12345, 16'd65535};
      foreach (values[i]) send_value(values[i]);
   endtask

   // Every decimal digit in every position.
   task automatic test_all_digits();
      for (int unsigned d = 0; d < 10; d++) begin
         send_value(16'(d * 1111));
      end
   endtask

   // Random values: half drawn within the shown range, half across the full field.
   // The first part runs with no sender gaps.
   task automatic test_random_values();
      logic [15:0] value;
      for (int unsigned n = 0; n < RandomValues; n++) begin
         sender_gaps = (n >= RandomValues / 3);
         if ($urandom_range(0, 1) == 0) begin
            value = 16'($urandom_range(0, 9999));
         end else begin
            value = 16'($urandom());
         end
         send_value(value);
      end
      sender_gaps = 1'b1;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_shown_value = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_all_digits();
      test_random_values();

      @(negedge clock);
      req_valid <= 1'b0;

      // Wait for every pending bit, then watch for stray transactions.
      while (pending_bits.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (pending_bits.size() != 0) begin
         report_mismatch($sformatf("%0d bits never arrived", pending_bits.size()));
      end

      if (error_count == 0) begin
         $display("PASS decimal_seven_segment_serial_driver");
      end else begin
         $display("FAIL decimal_seven_segment_serial_driver");
      end
      $finish;
   end

endmodule
`default_nettype wire
